/* design/fast_packet_autopilot_status_decoder_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the autopilot status decoder RTL
// Each macro expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef FAST_PACKET_AUTOPILOT_STATUS_DECODER_DEFINES_SVH
`define FAST_PACKET_AUTOPILOT_STATUS_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FPASD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FPASD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/fpasd_pkg.sv */
// ----------------------------------------------------------------------------
// fpasd_pkg
// Types and constants for the fast-packet autopilot status decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fpasd_pkg;

  // Buffer size default (bytes)
  localparam int BUFFER_BYTES_DEF = 32;

  // Identifier filter reset values
  localparam logic [28:0] MASK_RESET  = 29'h1FFF00FF;
  localparam logic [28:0] VALUE_RESET = 29'h1DEF0073;

  // Register indexes
  localparam logic REG_MATCH_MASK  = 1'b0;
  localparam logic REG_MATCH_VALUE = 1'b1;

  // Fast-packet framing
  localparam logic [7:0] FIRST_BYTES      = 8'd6;
  localparam logic [7:0] LATER_BYTES      = 8'd7;
  localparam logic [7:0] DATAGRAM_CODE    = 8'h84;
  localparam logic [7:0] MIN_DATAGRAM_LEN = 8'd11;

  // Angle arithmetic
  localparam logic [8:0] DEG_QUARTER = 9'd90;
  localparam logic [8:0] DEG_FULL    = 9'd360;

  // Pilot mode nibbles and broadcast codes
  localparam logic [3:0] MODE_STANDBY = 4'h0;
  localparam logic [3:0] MODE_AUTO    = 4'h2;
  localparam logic [3:0] MODE_WIND    = 4'h6;
  localparam logic [3:0] MODE_TRACK   = 4'hA;
  localparam logic [8:0] BCAST_STANDBY = 9'd0;
  localparam logic [8:0] BCAST_AUTO    = 9'd64;
  localparam logic [8:0] BCAST_WIND    = 9'd256;
  localparam logic [8:0] BCAST_TRACK   = 9'd384;

  // One memory row: the payload bytes of one frame, lane 0 first
  typedef logic [6:0][7:0] row_t;

  // Rows 0 and 1 fetched for decoding
  typedef struct packed {
    logic valid;
    row_t row0;
    row_t row1;
  } fetch_t;

  // One decoded status result
  typedef struct packed {
    logic [8:0]        heading_deg;
    logic [8:0]        course_deg;
    logic signed [7:0] rudder_deg;
    logic [3:0]        pilot_mode;
    logic [3:0]        alarm_bits;
    logic              mode_changed;
    logic [3:0]        alarm_onset;
    logic              broadcast_valid;
    logic [8:0]        broadcast_mode;
    logic [7:0]        alarm_byte;
  } result_t;

endpackage

`default_nettype wire

/* design/fpasd_reasm.sv */
// ----------------------------------------------------------------------------
// fpasd_reasm
// Frame filter, fast-packet sequencing and the frame-row payload memory.
// ----------------------------------------------------------------------------
`default_nettype none

module fpasd_reasm #(
  parameter int BUFFER_BYTES = fpasd_pkg::BUFFER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [28:0]      cfg_data,
  input  logic             take,
  input  logic             is_extended,
  input  logic             is_data,
  input  logic [28:0]      frame_id,
  input  logic [7:0]       byte_0,
  input  logic [7:0]       byte_1,
  input  logic [7:0]       byte_2,
  input  logic [7:0]       byte_3,
  input  logic [7:0]       byte_4,
  input  logic [7:0]       byte_5,
  input  logic [7:0]       byte_6,
  input  logic [7:0]       byte_7,
  output fpasd_pkg::fetch_t fetch
);
  import fpasd_pkg::*;

  // Frame 0 holds 6 bytes, every later frame 7: one row per frame index
  localparam int ROWS = BUFFER_BYTES / 7 + 1;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [28:0] match_mask;
  logic [28:0] match_value;

  logic [7:0] expected_length, expected_length_next;
  logic [7:0] bytes_received, bytes_received_next;
  logic [4:0] next_index, next_index_next;
  logic [2:0] packet_sequence, packet_sequence_next;

  logic [7:0] fb [8];
  logic       hit;
  logic [4:0] idx;
  logic [2:0] seq;
  logic [7:0] left;
  logic [7:0] n;
  logic [7:0] exp_upd;
  logic       done;
  logic       go;
  logic          wr_en;
  logic [AW-1:0] wr_row;
  row_t          wr_data;

  row_t mem [ROWS];
  row_t rd0;
  row_t rd1;
  logic fetch_valid;

  assign fb[0] = byte_0;
  assign fb[1] = byte_1;
  assign fb[2] = byte_2;
  assign fb[3] = byte_3;
  assign fb[4] = byte_4;
  assign fb[5] = byte_5;
  assign fb[6] = byte_6;
  assign fb[7] = byte_7;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_mask  <= MASK_RESET;
      match_value <= VALUE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MATCH_MASK:  match_mask  <= cfg_data;
        REG_MATCH_VALUE: match_value <= cfg_data;
      endcase
    end
  end

  // Frame filter
  assign hit = take & is_extended & is_data & ((frame_id & match_mask) == match_value);
  assign idx = fb[0][4:0];
  assign seq = fb[0][7:5];

  // Sequencing and row write
  always_comb begin
    exp_upd              = expected_length;
    bytes_received_next  = bytes_received;
    next_index_next      = next_index;
    packet_sequence_next = packet_sequence;
    wr_en   = 1'b0;
    wr_row  = '0;
    wr_data = '0;
    left    = '0;
    n       = '0;
    if (hit) begin
      if (idx == 5'd0) begin
        if (byte_1 == 8'd0 || byte_1 > 8'(BUFFER_BYTES)) begin
          exp_upd = 8'd0;
        end else begin
          exp_upd              = byte_1;
          bytes_received_next  = (byte_1 < FIRST_BYTES) ? byte_1 : FIRST_BYTES;
          packet_sequence_next = seq;
          next_index_next      = 5'd1;
          wr_en  = 1'b1;
          wr_row = '0;
          for (int j = 0; j < 6; j++) wr_data[j] = fb[j+2];
        end
      end else if (expected_length == 8'd0 || idx != next_index ||
                   seq != packet_sequence) begin
        exp_upd = 8'd0;
      end else begin
        left = (bytes_received < expected_length) ?
               (expected_length - bytes_received) : 8'd0;
        n    = (left < LATER_BYTES) ? left : LATER_BYTES;
        bytes_received_next = bytes_received + n;
        next_index_next     = next_index + 5'd1;
        wr_en  = ({3'b000, idx} < 8'(ROWS));
        wr_row = AW'(idx);
        for (int j = 0; j < 7; j++) wr_data[j] = fb[j+1];
      end
    end
    done = hit && (exp_upd != 8'd0) && (bytes_received_next >= exp_upd);
    go   = done && (exp_upd >= MIN_DATAGRAM_LEN);
    expected_length_next = done ? 8'd0 : exp_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= 8'd0;
      bytes_received  <= 8'd0;
      next_index      <= 5'd0;
      packet_sequence <= 3'd0;
      fetch_valid     <= 1'b0;
    end else begin
      expected_length <= expected_length_next;
      bytes_received  <= bytes_received_next;
      next_index      <= next_index_next;
      packet_sequence <= packet_sequence_next;
      fetch_valid     <= go;
    end
  end

  // Payload memory: one write port, rows 0 and 1 read for decoding
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_row] <= wr_data;
  end

  // Registered reads, forwarding a row written in the same cycle
  always_ff @(posedge clk) begin
    rd0 <= (wr_en && wr_row == AW'(0)) ? wr_data : mem[AW'(0)];
    rd1 <= (wr_en && wr_row == AW'(1)) ? wr_data : mem[AW'(1)];
  end

  assign fetch.valid = fetch_valid;
  assign fetch.row0  = rd0;
  assign fetch.row1  = rd1;

endmodule

`default_nettype wire

/* design/fpasd_decode.sv */
// ----------------------------------------------------------------------------
// fpasd_decode
// Decodes the 0x84 status datagram and tracks mode and alarm history.
// ----------------------------------------------------------------------------
`default_nettype none

module fpasd_decode (
  input  logic               clk,
  input  logic               rst,
  input  fpasd_pkg::fetch_t  fetch,
  output logic               push,
  output fpasd_pkg::result_t res
);
  import fpasd_pkg::*;

  logic [7:0] previous_mode;
  logic [7:0] previous_alarms;

  logic [7:0] b4, b5, vw, xy, b8, b9, b10;
  logic [3:0] u, z, m;
  logic [8:0] corr;
  logic [8:0] hdg_raw, crs_raw;
  logic [8:0] bmode;
  logic       bvalid;

  // Payload bytes 4 and 5 sit in row 0, bytes 6 to 10 in row 1
  assign b4  = fetch.row0[4];
  assign b5  = fetch.row0[5];
  assign vw  = fetch.row1[0];
  assign xy  = fetch.row1[1];
  assign b8  = fetch.row1[2];
  assign b9  = fetch.row1[3];
  assign b10 = fetch.row1[4];

  assign u = b5[7:4];
  assign z = b8[3:0];
  assign m = b9[3:0];

  // Heading and course, at most one wrap past 360
  always_comb begin
    unique case (u[3:2])
      2'b00:   corr = 9'd0;
      2'b11:   corr = 9'd2;
      default: corr = 9'd1;
    endcase
    hdg_raw = 9'(u[1:0]) * DEG_QUARTER + {2'b00, vw[5:0], 1'b0} + corr;
    crs_raw = 9'(vw[7:6]) * DEG_QUARTER + {2'b00, xy[7:1]};
  end

  // Broadcast mode code
  always_comb begin
    bvalid = 1'b1;
    unique case (z)
      MODE_STANDBY: bmode = BCAST_STANDBY;
      MODE_AUTO:    bmode = BCAST_AUTO;
      MODE_WIND:    bmode = BCAST_WIND;
      MODE_TRACK:   bmode = BCAST_TRACK;
      default: begin
        bmode  = BCAST_STANDBY;
        bvalid = 1'b0;
      end
    endcase
  end

  assign push = fetch.valid && (b4 == DATAGRAM_CODE);

  always_comb begin
    res.heading_deg     = (hdg_raw >= DEG_FULL) ? hdg_raw - DEG_FULL : hdg_raw;
    res.course_deg      = (crs_raw >= DEG_FULL) ? crs_raw - DEG_FULL : crs_raw;
    res.rudder_deg      = signed'(b10);
    res.pilot_mode      = z;
    res.alarm_bits      = m;
    res.mode_changed    = ({4'h0, z} != previous_mode);
    // equal history yields no onset either way
    res.alarm_onset     = m & ~previous_alarms[3:0];
    res.broadcast_valid = bvalid;
    res.broadcast_mode  = bmode;
    res.alarm_byte      = b9;
  end

  // History of the last decoded status
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_mode   <= 8'hFF;
      previous_alarms <= 8'hFF;
    end else if (push) begin
      previous_mode   <= {4'h0, z};
      previous_alarms <= {4'h0, m};
    end
  end

endmodule

`default_nettype wire

/* design/fpasd_outq.sv */
// ----------------------------------------------------------------------------
// fpasd_outq
// Two-entry result queue that decouples decoding from the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fast_packet_autopilot_status_decoder_defines.svh"

module fpasd_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  fpasd_pkg::result_t res_in,
  input  logic               inflight,
  input  logic               out_stall,
  output logic               out_valid,
  output fpasd_pkg::result_t head,
  output logic               full
);
  import fpasd_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  result_t    q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign head      = q[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // stop input while a decode in flight could find no slot
  assign full      = ({1'b0, count} + 3'(inflight)) >= {1'b0, DEPTH};

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= res_in;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `FPASD_ASSERT_IMP(a_no_overflow, clk, rst, push, (count < DEPTH) || pop, "result queue overflow")
  `FPASD_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= DEPTH, "result count out of range")
  `FPASD_ASSERT_NXT(a_pop_drains, clk, rst, pop && !push, count == $past(count) - 2'd1, "pop lost")

endmodule

`default_nettype wire

/* design/fast_packet_autopilot_status_decoder.sv */
// ----------------------------------------------------------------------------
// fast_packet_autopilot_status_decoder
// Reassembles fast-packet CAN frames and decodes autopilot status datagrams.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one received CAN frame per
//   request. Extended data frames whose masked identifier matches are
//   reassembled by frame index and sequence into a frame-row memory.
//   Output channel (out_valid / out_stall) carries one status result for
//   each completed packet holding an 0x84 datagram of 11 bytes or more.
//   Configuration: cfg_write with cfg_index 0 (match_mask) or 1 (match_value)
//   loads cfg_data at the clock edge; the user must write only while idle (unenforced).
// Timing:
//   One frame accepted per cycle while in_stall is low. A result is shown once
//   the completing frame has passed the registered read of memory rows 0 and
//   1 and then the decode into the two-entry result queue. in_stall rises only
//   when the queue is full, or holds one result with another decode in flight,
//   so frames keep flowing while one result waits.
// Reset:
//   Synchronous, active high. Filter returns to its defaults, reassembly
//   goes idle, the queue empties, mode and alarm history reads as 0xFF.
//   The payload memory is not cleared; only bytes of the current packet
//   are decoded.
// ----------------------------------------------------------------------------
`default_nettype none

module fast_packet_autopilot_status_decoder #(
  parameter int BUFFER_BYTES = fpasd_pkg::BUFFER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [28:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              is_extended,
  input  logic              is_data,
  input  logic [28:0]       frame_id,
  input  logic [7:0]        byte_0,
  input  logic [7:0]        byte_1,
  input  logic [7:0]        byte_2,
  input  logic [7:0]        byte_3,
  input  logic [7:0]        byte_4,
  input  logic [7:0]        byte_5,
  input  logic [7:0]        byte_6,
  input  logic [7:0]        byte_7,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [8:0]        heading_deg,
  output logic [8:0]        course_deg,
  output logic signed [7:0] rudder_deg,
  output logic [3:0]        pilot_mode,
  output logic [3:0]        alarm_bits,
  output logic              mode_changed,
  output logic [3:0]        alarm_onset,
  output logic              broadcast_valid,
  output logic [8:0]        broadcast_mode,
  output logic [7:0]        alarm_byte
);
  import fpasd_pkg::*;

  fetch_t  fetch;
  result_t dec_res;
  result_t head;
  logic    dec_push;
  logic    full;
  logic    take;

  assign in_stall = full;
  assign take     = in_valid && !in_stall;

  // Filter, sequencing and payload memory
  fpasd_reasm #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_reasm (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (take),
    .is_extended(is_extended),
    .is_data    (is_data),
    .frame_id   (frame_id),
    .byte_0     (byte_0),
    .byte_1     (byte_1),
    .byte_2     (byte_2),
    .byte_3     (byte_3),
    .byte_4     (byte_4),
    .byte_5     (byte_5),
    .byte_6     (byte_6),
    .byte_7     (byte_7),
    .fetch      (fetch)
  );

  // Datagram decode and history
  fpasd_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .fetch(fetch),
    .push (dec_push),
    .res  (dec_res)
  );

  // Result queue
  fpasd_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (dec_push),
    .res_in   (dec_res),
    .inflight (fetch.valid),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .head     (head),
    .full     (full)
  );

  assign heading_deg     = head.heading_deg;
  assign course_deg      = head.course_deg;
  assign rudder_deg      = head.rudder_deg;
  assign pilot_mode      = head.pilot_mode;
  assign alarm_bits      = head.alarm_bits;
  assign mode_changed    = head.mode_changed;
  assign alarm_onset     = head.alarm_onset;
  assign broadcast_valid = head.broadcast_valid;
  assign broadcast_mode  = head.broadcast_mode;
  assign alarm_byte      = head.alarm_byte;

endmodule

`default_nettype wire

/* dv/fast_packet_autopilot_status_decoder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fast_packet_autopilot_status_decoder_test
// Self-checking bench for the fast-packet autopilot status decoder. A short
// table of hand-built frames exercises the filter, reassembly corner cases
// and the decode extremes. Random well-formed packets follow, mixed with noise
// and broken sequences, under several identifier filter settings. Every
// accepted frame runs through a local reassembly and decode model, and each
// status that comes out is compared field by field against the oldest one
// waiting.
// ----------------------------------------------------------------------------
module fast_packet_autopilot_status_decoder_test;
  import fpasd_pkg::*;

  localparam int BUF_BYTES     = BUFFER_BYTES_DEF;
  localparam int IDLE_PCT      = 13;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int TIMEOUT_NS    = 2_000_000;

  // Identifiers that pass or fail the default filter
  localparam logic [28:0] ID_A   = 29'h1DEF0073;
  localparam logic [28:0] ID_B   = 29'h1DEF5A73;
  localparam logic [28:0] ID_OFF = 29'h1DEF0074;

  // One received CAN frame; data[0] is byte_0
  typedef struct packed {
    logic            ext;
    logic            dat;
    logic [28:0]     id;
    logic [0:7][7:0] data;
  } can_frame_t;

  // One request for the sender, with an optional hand-typed status
  typedef struct {
    can_frame_t frm;
    bit         typed;
    result_t    res;
  } frame_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_MATCH_MASK;
  logic [28:0] cfg_data = '0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        is_extended = 1'b0;
  logic        is_data = 1'b0;
  logic [28:0] frame_id = '0;
  logic [7:0]  byte_0 = '0;
  logic [7:0]  byte_1 = '0;
  logic [7:0]  byte_2 = '0;
  logic [7:0]  byte_3 = '0;
  logic [7:0]  byte_4 = '0;
  logic [7:0]  byte_5 = '0;
  logic [7:0]  byte_6 = '0;
  logic [7:0]  byte_7 = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [8:0]        heading_deg;
  logic [8:0]        course_deg;
  logic signed [7:0] rudder_deg;
  logic [3:0]        pilot_mode;
  logic [3:0]        alarm_bits;
  logic              mode_changed;
  logic [3:0]        alarm_onset;
  logic              broadcast_valid;
  logic [8:0]        broadcast_mode;
  logic [7:0]        alarm_byte;

  fast_packet_autopilot_status_decoder uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .is_extended     (is_extended),
    .is_data         (is_data),
    .frame_id        (frame_id),
    .byte_0          (byte_0),
    .byte_1          (byte_1),
    .byte_2          (byte_2),
    .byte_3          (byte_3),
    .byte_4          (byte_4),
    .byte_5          (byte_5),
    .byte_6          (byte_6),
    .byte_7          (byte_7),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .heading_deg     (heading_deg),
    .course_deg      (course_deg),
    .rudder_deg      (rudder_deg),
    .pilot_mode      (pilot_mode),
    .alarm_bits      (alarm_bits),
    .mode_changed    (mode_changed),
    .alarm_onset     (alarm_onset),
    .broadcast_valid (broadcast_valid),
    .broadcast_mode  (broadcast_mode),
    .alarm_byte      (alarm_byte)
  );

  // Clock: 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bench-side copy of the filter and the reassembly state
  logic [28:0] flt_mask  = MASK_RESET;
  logic [28:0] flt_value = VALUE_RESET;
  logic [7:0]  pk_buf [0:BUF_BYTES-1];
  logic [7:0]  pk_len = '0;
  logic [7:0]  pk_got = '0;
  logic [4:0]  pk_next = '0;
  logic [2:0]  pk_seq = '0;
  logic [7:0]  last_mode = 8'hFF;
  logic [7:0]  last_alarms = 8'hFF;

  frame_req_t dir_tab [$];
  frame_req_t frame_q [$];
  result_t    pending_status_q [$];
  frame_req_t cur;
  result_t    pred, got, want;
  bit         hit;
  int         frames_queued = 0;
  int         frames_taken = 0;
  int         err_cnt = 0;
  int         hold_cnt = 0;
  bit         quiet = 1'b0;
  bit         hold_on = 1'b0;

  // Reassemble one frame and decode the status if it completes a datagram
  task automatic predict_status(input can_frame_t f, output bit hit_o, output result_t r);
    logic [4:0] idx;
    logic [2:0] seq;
    logic [3:0] u, z, m;
    int n, left, k, hdg, crs, corr;
    hit_o = 1'b0;
    r = '0;
    idx = f.data[0][4:0];
    seq = f.data[0][7:5];
    if (f.ext && f.dat && ((f.id & flt_mask) == flt_value)) begin
      if (idx == 5'd0) begin
        // first frame: length check, then restart
        if (f.data[1] == 8'd0 || f.data[1] > BUF_BYTES) begin
          pk_len = '0;
        end else begin
          n = (f.data[1] < FIRST_BYTES) ? f.data[1] : FIRST_BYTES;
          pk_len = f.data[1];
          pk_got = 8'(n);
          pk_seq = seq;
          pk_next = 5'd1;
          for (k = 0; k < n; k++) pk_buf[k] = f.data[2+k];
        end
      end else if (pk_len == 8'd0 || idx != pk_next || seq != pk_seq) begin
        pk_len = '0;
      end else begin
        left = (pk_got < pk_len) ? pk_len - pk_got : 0;
        n = (left < LATER_BYTES) ? left : LATER_BYTES;
        for (k = 0; k < n; k++)
          if (pk_got + k < BUF_BYTES) pk_buf[pk_got+k] = f.data[1+k];
        pk_got = 8'(pk_got + n);
        pk_next = pk_next + 5'd1;
      end

      // packet complete: decode only a long enough status datagram
      if (pk_len != 8'd0 && pk_got >= pk_len) begin
        if (pk_len >= MIN_DATAGRAM_LEN && pk_buf[4] == DATAGRAM_CODE) begin
          u = pk_buf[5][7:4];
          z = pk_buf[8][3:0];
          m = pk_buf[9][3:0];
          case (u[3:2])
            2'b00:   corr = 0;
            2'b11:   corr = 2;
            default: corr = 1;
          endcase
          hdg = u[1:0] * DEG_QUARTER + pk_buf[6][5:0] * 2 + corr;
          crs = pk_buf[6][7:6] * DEG_QUARTER + pk_buf[7] / 2;
          r.heading_deg = 9'(hdg % DEG_FULL);
          r.course_deg = 9'(crs % DEG_FULL);
          r.rudder_deg = pk_buf[10];
          r.pilot_mode = z;
          r.alarm_bits = m;
          r.alarm_byte = pk_buf[9];
          r.broadcast_valid = 1'b1;
          case (z)
            MODE_STANDBY: r.broadcast_mode = BCAST_STANDBY;
            MODE_AUTO:    r.broadcast_mode = BCAST_AUTO;
            MODE_WIND:    r.broadcast_mode = BCAST_WIND;
            MODE_TRACK:   r.broadcast_mode = BCAST_TRACK;
            default: begin
              r.broadcast_mode = '0;
              r.broadcast_valid = 1'b0;
            end
          endcase
          // history: mode change and newly raised alarms
          r.mode_changed = ({4'h0, z} != last_mode);
          last_mode = {4'h0, z};
          if ({4'h0, m} != last_alarms) begin
            r.alarm_onset = m & ~last_alarms[3:0];
            last_alarms = {4'h0, m};
          end
          hit_o = 1'b1;
        end
        pk_len = '0;
      end
    end
  endtask

  function automatic frame_req_t mk_row(int ext, int dat, logic [28:0] id,
                                        logic [0:7][7:0] d, int typed, result_t res);
    frame_req_t q;
    q.frm.ext = ext[0];
    q.frm.dat = dat[0];
    q.frm.id = id;
    q.frm.data = d;
    q.typed = typed[0];
    q.res = res;
    return q;
  endfunction

  function automatic result_t status(int hdg, int crs, logic [7:0] rud,
                                     logic [3:0] mode, logic [3:0] alm, int chg,
                                     logic [3:0] onset, int bv, logic [8:0] bm,
                                     logic [7:0] ab);
    result_t r;
    r.heading_deg = 9'(hdg);
    r.course_deg = 9'(crs);
    r.rudder_deg = rud;
    r.pilot_mode = mode;
    r.alarm_bits = alm;
    r.mode_changed = chg[0];
    r.alarm_onset = onset;
    r.broadcast_valid = bv[0];
    r.broadcast_mode = bm;
    r.alarm_byte = ab;
    return r;
  endfunction

  function automatic logic [28:0] good_id();
    logic [28:0] raw;
    raw = 29'($urandom);
    return (raw & ~flt_mask) | flt_value;
  endfunction

  task automatic report(string what);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%s", what);
  endtask

  task automatic queue_req(frame_req_t q);
    frame_q.push_back(q);
    frames_queued++;
  endtask

  // Filtered-out frames and matching frames with random content
  task automatic queue_noise();
    logic ext, dat;
    logic [28:0] id;
    ext = 1'b1;
    dat = 1'b1;
    id = good_id();
    case ($urandom_range(0, 3))
      0: ext = 1'b0;
      1: dat = 1'b0;
      2: id = 29'($urandom);
      default: ;
    endcase
    queue_req(mk_row(ext, dat, id, {$urandom, $urandom}, 1'b0, '0));
  endtask

  // One fast packet, usually well formed, sometimes broken
  task automatic queue_random_packet();
    logic [7:0] pl [0:BUF_BYTES-1];
    logic [0:7][7:0] d;
    logic [2:0] seq;
    logic [28:0] id;
    int len, later, roll, bad_at, bad_kind, k, j, pos;
    roll = $urandom_range(0, 99);
    if (roll < 60) len = $urandom_range(11, 14);
    else if (roll < 80) len = $urandom_range(15, BUF_BYTES);
    else if (roll < 90) len = $urandom_range(1, 10);
    else if (roll < 95) len = 0;
    else len = $urandom_range(BUF_BYTES + 1, 255);
    for (k = 0; k < BUF_BYTES; k++) pl[k] = 8'($urandom);
    if ($urandom_range(0, 9) != 0) pl[4] = DATAGRAM_CODE;
    case ($urandom_range(0, 4))
      0: pl[8][3:0] = MODE_STANDBY;
      1: pl[8][3:0] = MODE_AUTO;
      2: pl[8][3:0] = MODE_WIND;
      3: pl[8][3:0] = MODE_TRACK;
      default: ;
    endcase
    // keep alarms to the real bits half the time so they repeat
    if ($urandom_range(0, 1) != 0) pl[9][3:0] = {2'($urandom_range(0, 3)), 2'b00};
    seq = 3'($urandom);
    id = good_id();
    later = (len > 6) ? (len - 6 + 6) / 7 : 0;
    if (later > 4) later = $urandom_range(1, 4);
    bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, later) : -1;
    bad_kind = $urandom_range(0, 3);
    for (k = 0; k <= later; k++) begin
      if ($urandom_range(0, 9) == 0) queue_noise();
      if (k == 0) begin
        d = {seq, 5'd0, 8'(len), pl[0], pl[1], pl[2], pl[3], pl[4], pl[5]};
      end else begin
        d[0] = {seq, 5'(k)};
        for (j = 1; j < 8; j++) begin
          pos = 6 + 7 * (k - 1) + j - 1;
          d[j] = (pos < BUF_BYTES) ? pl[pos] : 8'($urandom);
        end
      end
      if (k == bad_at) begin
        case (bad_kind)
          0: d[0][4:0] = d[0][4:0] + 5'd1;
          1: d[0][7:5] = d[0][7:5] + 3'd1;
          2: queue_noise();
          default: ;
        endcase
      end
      // a dropped frame is simply never queued
      if (!(k == bad_at && bad_kind == 3))
        queue_req(mk_row(1'b1, 1'b1, id, d, 1'b0, '0));
    end
  endtask

  // Random phase, closed by a bad first frame so reassembly ends idle
  task automatic queue_random(int n);
    int start;
    start = frames_queued;
    while (frames_queued - start < n) queue_random_packet();
    queue_req(mk_row(1'b1, 1'b1, good_id(), 64'h00_00_00_00_00_00_00_00, 1'b0, '0));
  endtask

  // Wait until every frame is taken and every status has come back
  task automatic drain();
    while (frames_taken != frames_queued || pending_status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [28:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_MATCH_MASK) flt_mask = val;
    else flt_value = val;
  endtask

  // Sender: offer frames, hold while stalled, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_status(cur.frm, hit, pred);
        if (cur.typed) pending_status_q.push_back(cur.res);
        else if (hit) pending_status_q.push_back(pred);
        frames_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (frame_q.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur = frame_q.pop_front();
          in_valid <= 1'b1;
          is_extended <= cur.frm.ext;
          is_data <= cur.frm.dat;
          frame_id <= cur.frm.id;
          byte_0 <= cur.frm.data[0];
          byte_1 <= cur.frm.data[1];
          byte_2 <= cur.frm.data[2];
          byte_3 <= cur.frm.data[3];
          byte_4 <= cur.frm.data[4];
          byte_5 <= cur.frm.data[5];
          byte_6 <= cur.frm.data[6];
          byte_7 <= cur.frm.data[7];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each status, stall at random or for one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.heading_deg = heading_deg;
        got.course_deg = course_deg;
        got.rudder_deg = rudder_deg;
        got.pilot_mode = pilot_mode;
        got.alarm_bits = alarm_bits;
        got.mode_changed = mode_changed;
        got.alarm_onset = alarm_onset;
        got.broadcast_valid = broadcast_valid;
        got.broadcast_mode = broadcast_mode;
        got.alarm_byte = alarm_byte;
        if (pending_status_q.size() == 0) begin
          report($sformatf("unexpected status at %0t: hdg %0d crs %0d mode %h",
                           $realtime, heading_deg, course_deg, pilot_mode));
        end else begin
          want = pending_status_q.pop_front();
          if (got.heading_deg !== want.heading_deg || got.course_deg !== want.course_deg ||
              got.rudder_deg !== want.rudder_deg || got.pilot_mode !== want.pilot_mode ||
              got.alarm_bits !== want.alarm_bits || got.mode_changed !== want.mode_changed ||
              got.alarm_onset !== want.alarm_onset ||
              got.broadcast_valid !== want.broadcast_valid ||
              got.broadcast_mode !== want.broadcast_mode ||
              got.alarm_byte !== want.alarm_byte)
            report($sformatf({"status mismatch at %0t (exp/got): hdg %0d/%0d crs %0d/%0d",
                              " rud %0d/%0d mode %h/%h alm %h/%h chg %b/%b onset %h/%h",
                              " bv %b/%b bm %0d/%0d ab %h/%h"}, $realtime,
                             want.heading_deg, got.heading_deg, want.course_deg,
                             got.course_deg, want.rudder_deg, got.rudder_deg,
                             want.pilot_mode, got.pilot_mode, want.alarm_bits,
                             got.alarm_bits, want.mode_changed, got.mode_changed,
                             want.alarm_onset, got.alarm_onset, want.broadcast_valid,
                             got.broadcast_valid, want.broadcast_mode,
                             got.broadcast_mode, want.alarm_byte, got.alarm_byte));
        end
      end
      if (hold_on && hold_cnt < HOLD_CYCLES) begin
        hold_cnt++;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Main sequence
  initial begin
    // directed table under the reset filter
    // decode after reset: all zero, mode counts as changed
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'h00_0B_00_00_00_00_84_00, 0, '0));
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'h01_00_00_00_00_00_AA_55, 1,
      status(0, 0, 8'h00, MODE_STANDBY, 4'h0, 1, 4'h0, 1, BCAST_STANDBY, 8'h00)));
    // all ones, top sequence: both angles wrap, unmapped mode
    dir_tab.push_back(mk_row(1, 1, ID_B, 64'hE0_0B_FF_FF_FF_FF_84_F0, 0, '0));
    dir_tab.push_back(mk_row(1, 1, ID_B, 64'hE1_FF_FF_FF_FF_80_FF_FF, 1,
      status(38, 37, 8'h80, 4'hF, 4'hF, 1, 4'hF, 0, 9'd0, 8'hFF)));
    // auto mode, alarms drop without onset
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'h60_0B_11_22_33_44_84_40, 0, '0));
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'h61_40_02_12_0C_7F_00_00, 1,
      status(1, 91, 8'h7F, MODE_AUTO, 4'hC, 1, 4'h0, 1, BCAST_AUTO, 8'h0C)));
    // track mode in a full-buffer packet of five frames
    dir_tab.push_back(mk_row(1, 1, ID_B, 64'h40_20_01_02_03_04_84_20, 0, '0));
    dir_tab.push_back(mk_row(1, 1, ID_B, 64'h41_80_00_0A_03_FF_0B_0C, 0, '0));
    dir_tab.push_back(mk_row(1, 1, ID_B, 64'h42_0D_0E_0F_10_11_12_13, 0, '0));
    dir_tab.push_back(mk_row(1, 1, ID_B, 64'h43_14_15_16_17_18_19_1A, 0, '0));
    dir_tab.push_back(mk_row(1, 1, ID_B, 64'h44_1B_1C_1D_1E_1F_5A_A5, 1,
      status(180, 180, 8'hFF, MODE_TRACK, 4'h3, 1, 4'h3, 1, BCAST_TRACK, 8'h03)));
    // unused frames: standard id, remote request, id mismatch
    dir_tab.push_back(mk_row(0, 1, ID_A, 64'h00_0B_00_00_00_00_84_00, 0, '0));
    dir_tab.push_back(mk_row(1, 0, ID_A, 64'h00_0B_00_00_00_00_84_00, 0, '0));
    dir_tab.push_back(mk_row(1, 1, ID_OFF, 64'h00_0B_00_00_00_00_84_00, 0, '0));
    // bad lengths: zero and one past the buffer
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'h00_00_00_00_00_00_84_00, 0, '0));
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'h00_21_00_00_00_00_84_00, 0, '0));
    // restart: a new first frame drops the packet in progress
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'h40_14_00_00_00_00_84_00, 0, '0));
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'hA0_0B_00_00_00_00_84_30, 0, '0));
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'hA1_C5_10_06_08_E0_00_00, 0, '0));
    // foreign datagram code
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'h00_0B_00_00_00_00_83_00, 0, '0));
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'h01_00_00_02_00_00_00_00, 0, '0));
    // wrong sequence, then a later frame while idle
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'h20_0B_00_00_00_00_84_00, 0, '0));
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'h41_00_00_06_00_00_00_00, 0, '0));
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'h21_00_00_06_00_00_00_00, 0, '0));
    // wrong index
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'h00_0B_00_00_00_00_84_00, 0, '0));
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'h02_00_00_06_00_00_00_00, 0, '0));
    // short datagram in a single frame
    dir_tab.push_back(mk_row(1, 1, ID_A, 64'h00_05_00_00_00_00_84_00, 0, '0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) queue_req(dir_tab[i]);
    queue_random(300);
    drain();

    // accept everything, no idling on either side
    write_reg(REG_MATCH_MASK, 29'h0000000);
    write_reg(REG_MATCH_VALUE, 29'h0000000);
    quiet = 1'b1;
    queue_random(300);
    drain();
    quiet = 1'b0;

    // exact id match; receiver holds off once, long enough for the block to back up
    write_reg(REG_MATCH_MASK, 29'h1FFFFFFF);
    write_reg(REG_MATCH_VALUE, 29'($urandom));
    hold_on = 1'b1;
    queue_random(300);
    drain();

    // random filter
    write_reg(REG_MATCH_MASK, 29'($urandom));
    write_reg(REG_MATCH_VALUE, 29'($urandom & flt_mask));
    queue_random(350);
    drain();

    // value outside the mask: nothing can match
    write_reg(REG_MATCH_MASK, 29'($urandom & 29'h0FFFFFFF));
    write_reg(REG_MATCH_VALUE, 29'($urandom | 29'h10000000));
    queue_random(50);
    drain();

    // back to the reset filter
    write_reg(REG_MATCH_MASK, MASK_RESET);
    write_reg(REG_MATCH_VALUE, VALUE_RESET);
    queue_random(350);
    drain();

    if (err_cnt == 0) begin
      $display("[fast_packet_autopilot_status_decoder] OK");
    end else begin
      $display("[fast_packet_autopilot_status_decoder] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("[fast_packet_autopilot_status_decoder] ERROR");
    $finish;
  end

endmodule
